// ===== rtl/tcc_pkg.sv =====
// Shared widths, constants and sideband types for the tilt-compensated compass.
`timescale 1ns / 1ps
`default_nettype none
package tcc_pkg;

  // angle format: signed degrees * 2^15
  localparam int ZW = 26;
  // accelerometer vectoring path width (inputs * 2^8 plus CORDIC gain)
  localparam int AW = 27;
  // sin/cos width (* 2^30)
  localparam int RW = 33;
  // tilt-compensated terms (* 2^8)
  localparam int YW = 27;
  localparam int XW = 28;
  // magnetic vectoring path width
  localparam int MW = 30;
  // product of the magnitude and 1/K
  localparam int PW = 58;

  localparam int TAB_LEN = 24;

  localparam logic signed [ZW-1:0] A90  = 26'sd2949120;
  localparam logic signed [ZW-1:0] A180 = 26'sd5898240;
  localparam logic signed [31:0]   INV_K = 32'sd652032874;

  localparam logic signed [15:0] DECL_RESET = 16'sd6400;
  localparam int FULL_TURN   = 46080;
  localparam int SECTOR_W    = 5760;
  localparam int HALF_SECTOR = 2880;
  localparam int ROLL_LIM    = 23040;
  localparam int PITCH_LIM   = 11520;

  // atan(2^-i) in degrees * 2^15, rounded to nearest
  localparam int ATAN_TAB [TAB_LEN] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  // sideband carried through the roll vectoring pipeline
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [16:0] mx;
    logic signed [16:0] my;
    logic signed [16:0] mz;
  } a_side_t;

  // sideband carried through the pitch vectoring pipeline
  typedef struct packed {
    logic signed [ZW-1:0] angr;
    logic signed [16:0]   my;
    logic signed [16:0]   mz;
  } c_side_t;

  // sideband carried through the pitch sin/cos pipeline
  typedef struct packed {
    logic signed [ZW-1:0] angr;
    logic signed [ZW-1:0] angp;
    logic signed [RW-1:0] sr;
    logic signed [RW-1:0] cr;
    logic signed [16:0]   mx;
    logic signed [16:0]   my;
    logic signed [16:0]   mz;
  } d_side_t;

  // roll and pitch carried to the output stage
  typedef struct packed {
    logic signed [ZW-1:0] angr;
    logic signed [ZW-1:0] angp;
  } ang_pair_t;

endpackage
`default_nettype wire

// ===== rtl/tcc_if.sv =====
// Valid/ready channel interfaces for sensor samples and heading results.
`timescale 1ns / 1ps
`default_nettype none
interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [16:0] mag_x;
  logic signed [16:0] mag_y;
  logic signed [16:0] mag_z;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic [15:0]        heading_angle;
  logic [2:0]         compass_sector;

  modport source (output valid, roll_angle, pitch_angle, heading_angle, compass_sector,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, heading_angle, compass_sector,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/tcc_vec.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) and gained magnitude, one iteration per stage.
`timescale 1ns / 1ps
`default_nettype none
module tcc_vec import tcc_pkg::*; #(
  parameter int W      = 27,
  parameter int STAGES = 16,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  in_x,
  input  logic signed [W-1:0]  in_y,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output logic signed [W-1:0]  out_mag,
  output logic [SW-1:0]        out_side
);

  logic                 vs   [0:STAGES];
  logic                 zf   [0:STAGES];
  logic signed [W-1:0]  xs   [0:STAGES];
  logic signed [W-1:0]  ys   [0:STAGES];
  logic signed [ZW-1:0] zs   [0:STAGES];
  logic [SW-1:0]        side [0:STAGES];

  logic signed [W-1:0]  x0_next;
  logic signed [W-1:0]  y0_next;
  logic signed [ZW-1:0] z0_next;

  // fold the left half plane onto the right one
  always_comb begin
    x0_next = in_x;
    y0_next = in_y;
    z0_next = '0;
    if (in_x < 0) begin
      x0_next = -in_x;
      y0_next = -in_y;
      z0_next = (in_y >= 0) ? A180 : -A180;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
    if (en) begin
      zf[0]   <= (in_x == '0) && (in_y == '0);
      xs[0]   <= x0_next;
      ys[0]   <= y0_next;
      zs[0]   <= z0_next;
      side[0] <= in_side;
    end
  end

  // one micro-rotation per stage, driving y toward zero
  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else if (en) begin
        vs[g+1] <= vs[g];
      end
      if (en) begin
        zf[g+1]   <= zf[g];
        side[g+1] <= side[g];
        if (ys[g] >= 0) begin
          xs[g+1] <= xs[g] + (ys[g] >>> g);
          ys[g+1] <= ys[g] - (xs[g] >>> g);
          zs[g+1] <= zs[g] + ZW'(ATAN_TAB[g]);
        end else begin
          xs[g+1] <= xs[g] - (ys[g] >>> g);
          ys[g+1] <= ys[g] + (xs[g] >>> g);
          zs[g+1] <= zs[g] - ZW'(ATAN_TAB[g]);
        end
      end
    end
  end

  // zero vector reports angle 0
  assign out_valid = vs[STAGES];
  assign out_z     = zf[STAGES] ? '0 : zs[STAGES];
  assign out_mag   = xs[STAGES];
  assign out_side  = side[STAGES];

endmodule
`default_nettype wire

// ===== rtl/tcc_rot.sv =====
// Pipelined rotation CORDIC: sin and cos (* 2^30) of an angle in degrees * 2^15.
`timescale 1ns / 1ps
`default_nettype none
module tcc_rot import tcc_pkg::*; #(
  parameter int STAGES = 16,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [RW-1:0] out_sin,
  output logic signed [RW-1:0] out_cos,
  output logic [SW-1:0]        out_side
);

  logic                 vs   [0:STAGES];
  logic                 ng   [0:STAGES];
  logic signed [RW-1:0] xs   [0:STAGES];
  logic signed [RW-1:0] ys   [0:STAGES];
  logic signed [ZW-1:0] zs   [0:STAGES];
  logic [SW-1:0]        side [0:STAGES];

  logic signed [ZW-1:0] z0_next;
  logic                 ng0_next;

  // fold angles beyond +-90 degrees by a half turn, negate at the end
  always_comb begin
    z0_next  = in_z;
    ng0_next = 1'b0;
    if (in_z > A90) begin
      z0_next  = in_z - A180;
      ng0_next = 1'b1;
    end else if (in_z < -A90) begin
      z0_next  = in_z + A180;
      ng0_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
    if (en) begin
      ng[0]   <= ng0_next;
      xs[0]   <= RW'(INV_K);
      ys[0]   <= '0;
      zs[0]   <= z0_next;
      side[0] <= in_side;
    end
  end

  // one micro-rotation per stage, driving z toward zero
  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else if (en) begin
        vs[g+1] <= vs[g];
      end
      if (en) begin
        ng[g+1]   <= ng[g];
        side[g+1] <= side[g];
        if (zs[g] >= 0) begin
          xs[g+1] <= xs[g] - (ys[g] >>> g);
          ys[g+1] <= ys[g] + (xs[g] >>> g);
          zs[g+1] <= zs[g] - ZW'(ATAN_TAB[g]);
        end else begin
          xs[g+1] <= xs[g] + (ys[g] >>> g);
          ys[g+1] <= ys[g] - (xs[g] >>> g);
          zs[g+1] <= zs[g] + ZW'(ATAN_TAB[g]);
        end
      end
    end
  end

  assign out_valid = vs[STAGES];
  assign out_sin   = ng[STAGES] ? -ys[STAGES] : ys[STAGES];
  assign out_cos   = ng[STAGES] ? -xs[STAGES] : xs[STAGES];
  assign out_side  = side[STAGES];

endmodule
`default_nettype wire

// ===== rtl/tcc_tilt.sv =====
// Four-stage tilt compensation of the magnetic vector (Xh, Yh in * 2^8).
`timescale 1ns / 1ps
`default_nettype none
module tcc_tilt import tcc_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [RW-1:0] sr,
  input  logic signed [RW-1:0] cr,
  input  logic signed [RW-1:0] sp,
  input  logic signed [RW-1:0] cp,
  input  logic signed [16:0]   mx,
  input  logic signed [16:0]   my,
  input  logic signed [16:0]   mz,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_xh,
  output logic signed [YW-1:0] out_yh,
  output logic [SW-1:0]        out_side
);

  localparam int P1W = 17 + RW;
  localparam int P6W = YW + RW;

  logic                  v1, v2, v3, v4;
  logic [SW-1:0]         s1, s2, s3, s4;
  logic signed [P1W-1:0] p1, p2, p3, p4, p5;
  logic signed [RW-1:0]  sp1, sp2;
  logic signed [YW-1:0]  yh2, tt2, yh3, yh4;
  logic signed [XW-1:0]  x12, x13, xh4;
  logic signed [P6W-1:0] p6;

  logic signed [P1W:0]   sum_y, sum_t;
  logic signed [P1W-1:0] sum_x;
  logic signed [P6W-1:0] sum_6;

  // stage 1: the five products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      p1  <= P1W'(mz) * P1W'(sr);
      p2  <= P1W'(my) * P1W'(cr);
      p3  <= P1W'(my) * P1W'(sr);
      p4  <= P1W'(mz) * P1W'(cr);
      p5  <= P1W'(mx) * P1W'(cp);
      sp1 <= sp;
      s1  <= in_side;
    end
  end

  // stage 2: sums, rounded half up to * 2^8
  always_comb begin
    sum_y = (P1W+1)'(p1) - (P1W+1)'(p2) + ((P1W+1)'(1) <<< 21);
    sum_t = (P1W+1)'(p3) + (P1W+1)'(p4) + ((P1W+1)'(1) <<< 21);
    sum_x = p5 + (P1W'(1) <<< 21);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      yh2 <= sum_y[22+YW-1:22];
      tt2 <= sum_t[22+YW-1:22];
      x12 <= sum_x[22+XW-1:22];
      sp2 <= sp1;
      s2  <= s1;
    end
  end

  // stage 3: T * sin(pitch)
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      p6  <= P6W'(tt2) * P6W'(sp2);
      yh3 <= yh2;
      x13 <= x12;
      s3  <= s2;
    end
  end

  // stage 4: Xh = round(mx*cos p) + round(T*sin p)
  assign sum_6 = p6 + (P6W'(1) <<< 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      xh4 <= x13 + sum_6[30+XW-1:30];
      yh4 <= yh3;
      s4  <= s3;
    end
  end

  assign out_valid = v4;
  assign out_xh    = xh4;
  assign out_yh    = yh4;
  assign out_side  = s4;

endmodule
`default_nettype wire

// ===== rtl/tcc_head.sv =====
// Output stages: angle rounding and clamping, heading wrap and sector lookup.
`timescale 1ns / 1ps
`default_nettype none
module tcc_head import tcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] in_roll,
  input  logic signed [ZW-1:0] in_pitch,
  input  logic signed [ZW-1:0] in_yaw,
  input  logic signed [15:0]   decl,
  output logic                 out_valid,
  output logic signed [15:0]   out_roll,
  output logic signed [14:0]   out_pitch,
  output logic [15:0]          out_heading,
  output logic [2:0]           out_sector
);

  localparam int RNW = ZW - 7;

  logic                  v1, v2, v3;
  logic signed [15:0]    roll1, roll2, roll3;
  logic signed [14:0]    pitch1, pitch2, pitch3;
  logic signed [19:0]    h1;
  logic [15:0]           h2, h3;
  logic [2:0]            sec3;

  logic signed [ZW:0]    r_sum, p_sum, y_sum;
  logic signed [RNW-1:0] r_rnd, p_rnd, y_rnd;
  logic signed [RNW-1:0] r_clp, p_clp;
  logic signed [19:0]    h_wrap;
  logic [3:0]            cnt;

  // round to 1/128 degree, clamp roll and pitch, add declination
  always_comb begin
    r_sum = (ZW+1)'(in_roll) + (ZW+1)'(128);
    p_sum = (ZW+1)'(in_pitch) + (ZW+1)'(128);
    y_sum = (ZW+1)'(in_yaw) + (ZW+1)'(128);
    r_rnd = r_sum[ZW:8];
    p_rnd = p_sum[ZW:8];
    y_rnd = y_sum[ZW:8];
    r_clp = r_rnd;
    if (r_rnd > RNW'(ROLL_LIM)) begin
      r_clp = RNW'(ROLL_LIM);
    end else if (r_rnd < -RNW'(ROLL_LIM)) begin
      r_clp = -RNW'(ROLL_LIM);
    end
    p_clp = p_rnd;
    if (p_rnd > RNW'(PITCH_LIM)) begin
      p_clp = RNW'(PITCH_LIM);
    end else if (p_rnd < -RNW'(PITCH_LIM)) begin
      p_clp = -RNW'(PITCH_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      roll1  <= r_clp[15:0];
      pitch1 <= p_clp[14:0];
      h1     <= 20'(y_rnd) + 20'(decl);
    end
  end

  // wrap into one turn; the sum stays within two turns either way
  always_comb begin
    if (h1 >= 20'(FULL_TURN)) begin
      h_wrap = h1 - 20'(FULL_TURN);
    end else if (h1 >= 0) begin
      h_wrap = h1;
    end else if (h1 >= -20'(FULL_TURN)) begin
      h_wrap = h1 + 20'(FULL_TURN);
    end else begin
      h_wrap = h1 + 20'(2 * FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      roll2  <= roll1;
      pitch2 <= pitch1;
      h2     <= h_wrap[15:0];
    end
  end

  // sector: count edges at or below the heading; an edge belongs to the next sector
  always_comb begin
    cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      if ({1'b0, h2} >= 17'(k * SECTOR_W - HALF_SECTOR)) begin
        cnt = cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      roll3  <= roll2;
      pitch3 <= pitch2;
      h3     <= h2;
      sec3   <= cnt[2:0];
    end
  end

  assign out_valid   = v3;
  assign out_roll    = roll3;
  assign out_pitch   = pitch3;
  assign out_heading = h3;
  assign out_sector  = sec3;

endmodule
`default_nettype wire

// ===== rtl/tilt_compensated_compass_heading.sv =====
// Throughput: one sample per cycle while no result waits untaken; the CORDIC pipelines
// run one iteration per stage. The whole pipeline holds while a result waits untaken;
// a sample is taken in that cycle only if the pipeline can move. Synchronous active-high
// reset clears all valid bits and loads the declination register with 50 degrees.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_compass_heading import tcc_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata,
  tcc_in_if.sink             sample,
  tcc_out_if.source          result
);

  logic               en;
  logic signed [15:0] decl;

  // roll vectoring
  a_side_t              a_in, a_out;
  logic                 v_a;
  logic signed [ZW-1:0] angr_a;
  logic signed [AW-1:0] mag_a;
  logic signed [AW-1:0] ax_s, ay_s, az_s;

  // magnitude scaling
  logic                 v_b1, v_b2;
  logic signed [PW-1:0] prod_b1, prod_rnd;
  logic signed [ZW-1:0] angr_b1, angr_b2;
  a_side_t              s_b1, s_b2;
  logic signed [AW-1:0] rad_b2;

  // pitch vectoring and roll sin/cos
  c_side_t              c_in, c_out;
  logic                 v_c, v_r1;
  logic signed [ZW-1:0] zp_c;
  logic signed [RW-1:0] sin_r1, cos_r1;
  logic signed [16:0]   mx_r1;

  // pitch sin/cos
  d_side_t              d_in, d_out;
  logic                 v_d;
  logic signed [RW-1:0] sp_d, cp_d;

  // tilt and yaw
  ang_pair_t            e_in, e_out, f_out;
  logic                 v_e, v_f;
  logic signed [XW-1:0] xh_e;
  logic signed [YW-1:0] yh_e;
  logic signed [ZW-1:0] angy_f;

  // global advance: pipeline moves unless the output register is full and stalled
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // declination register
  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= DECL_RESET;
    end else if (cfg_we) begin
      decl <= cfg_wdata;
    end
  end

  // roll = atan2(ay, az), operands scaled by 2^8
  assign az_s    = AW'(sample.accel_z) <<< 8;
  assign ay_s    = AW'(sample.accel_y) <<< 8;
  assign a_in.ax = sample.accel_x;
  assign a_in.mx = sample.mag_x;
  assign a_in.my = sample.mag_y;
  assign a_in.mz = sample.mag_z;

  tcc_vec #(.W(AW), .STAGES(CORDIC_STAGES), .SW($bits(a_side_t))) u_vec_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .in_x      (az_s),
    .in_y      (ay_s),
    .in_side   (a_in),
    .out_valid (v_a),
    .out_z     (angr_a),
    .out_mag   (mag_a),
    .out_side  (a_out)
  );

  // yz magnitude: gained CORDIC magnitude times 1/K, rounded half up
  assign prod_rnd = prod_b1 + (PW'(1) <<< 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0;
      v_b2 <= 1'b0;
    end else if (en) begin
      v_b1 <= v_a;
      v_b2 <= v_b1;
    end
    if (en) begin
      prod_b1 <= PW'(mag_a) * PW'(INV_K);
      angr_b1 <= angr_a;
      s_b1    <= a_out;
      rad_b2  <= prod_rnd[30+AW-1:30];
      angr_b2 <= angr_b1;
      s_b2    <= s_b1;
    end
  end

  // pitch = -atan2(ax, |yz|), alongside sin/cos of roll
  assign ax_s      = AW'(s_b2.ax) <<< 8;
  assign c_in.angr = angr_b2;
  assign c_in.my   = s_b2.my;
  assign c_in.mz   = s_b2.mz;

  tcc_vec #(.W(AW), .STAGES(CORDIC_STAGES), .SW($bits(c_side_t))) u_vec_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_b2),
    .in_x      (rad_b2),
    .in_y      (ax_s),
    .in_side   (c_in),
    .out_valid (v_c),
    .out_z     (zp_c),
    .out_mag   (),
    .out_side  (c_out)
  );

  tcc_rot #(.STAGES(CORDIC_STAGES), .SW(17)) u_rot_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_b2),
    .in_z      (angr_b2),
    .in_side   (s_b2.mx),
    .out_valid (v_r1),
    .out_sin   (sin_r1),
    .out_cos   (cos_r1),
    .out_side  (mx_r1)
  );

  // sin/cos of pitch
  assign d_in.angr = c_out.angr;
  assign d_in.angp = -zp_c;
  assign d_in.sr   = sin_r1;
  assign d_in.cr   = cos_r1;
  assign d_in.mx   = mx_r1;
  assign d_in.my   = c_out.my;
  assign d_in.mz   = c_out.mz;

  tcc_rot #(.STAGES(CORDIC_STAGES), .SW($bits(d_side_t))) u_rot_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_c & v_r1),
    .in_z      (d_in.angp),
    .in_side   (d_in),
    .out_valid (v_d),
    .out_sin   (sp_d),
    .out_cos   (cp_d),
    .out_side  (d_out)
  );

  // tilt compensation
  assign e_in.angr = d_out.angr;
  assign e_in.angp = d_out.angp;

  tcc_tilt #(.SW($bits(ang_pair_t))) u_tilt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d),
    .sr        (d_out.sr),
    .cr        (d_out.cr),
    .sp        (sp_d),
    .cp        (cp_d),
    .mx        (d_out.mx),
    .my        (d_out.my),
    .mz        (d_out.mz),
    .in_side   (e_in),
    .out_valid (v_e),
    .out_xh    (xh_e),
    .out_yh    (yh_e),
    .out_side  (e_out)
  );

  // yaw = atan2(Yh, Xh)
  tcc_vec #(.W(MW), .STAGES(CORDIC_STAGES), .SW($bits(ang_pair_t))) u_vec_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_e),
    .in_x      (MW'(xh_e)),
    .in_y      (MW'(yh_e)),
    .in_side   (e_out),
    .out_valid (v_f),
    .out_z     (angy_f),
    .out_mag   (),
    .out_side  (f_out)
  );

  // output register stages
  tcc_head u_head (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (v_f),
    .in_roll     (f_out.angr),
    .in_pitch    (f_out.angp),
    .in_yaw      (angy_f),
    .decl        (decl),
    .out_valid   (result.valid),
    .out_roll    (result.roll_angle),
    .out_pitch   (result.pitch_angle),
    .out_heading (result.heading_angle),
    .out_sector  (result.compass_sector)
  );

`ifndef SYNTHESIS
  // a stalled result freezes the pipeline, so no sample may be taken
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("sample taken while result stalled");

  // a stalled result must not be overwritten by the next one
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid &&
      $stable(result.heading_angle) && $stable(result.compass_sector))
    else $error("stalled result changed");

  // wrapped heading stays inside one turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.heading_angle < 16'(FULL_TURN))
    else $error("heading out of range");

  // roll and pitch stay inside their clamp limits
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.roll_angle <= 16'sd23040 && result.roll_angle >= -16'sd23040 &&
      result.pitch_angle <= 15'sd11520 && result.pitch_angle >= -15'sd11520)
    else $error("roll or pitch beyond clamp");
`endif

endmodule
`default_nettype wire
